### hw/rtl/assert_macros.svh
// assertion macros for the rtl files
// no dependencies; included by modules that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define FCAC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define FCAC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### hw/rtl/fcac_pkg.sv
// types and constants of the length-prefixed frame checker
// no dependencies; used by the channel interfaces, the result queue and the top level
package fcac_pkg;

   localparam logic [7:0] START_MARK = 8'h24;
   localparam logic [7:0] END_MARK   = 8'h23;
   localparam logic [8:0] LEN_INDEX  = 9'd7;
   localparam logic [8:0] SUM_INDEX  = 9'd6;
   localparam logic [8:0] INDEX_MAX  = 9'd263;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_FRAME_ERR = 2'd1,
      STATUS_SUM_ERR   = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  frame_length;
   } rsp_word_type;

   // queue state seen by the top level
   typedef struct packed {
      logic head_valid;
      logic full;
   } queue_status_type;

endpackage

### hw/rtl/fcac_if.sv
// valid/ready channel interfaces for frame bytes and check results
// depends on fcac_pkg
interface fcac_req_if;
   logic       valid;
   logic       ready;
   logic       first_byte;
   logic [7:0] data_byte;

   modport source (output valid, output first_byte, output data_byte, input ready);
   modport sink   (input valid, input first_byte, input data_byte, output ready);
endinterface

interface fcac_rsp_if import fcac_pkg::*; ;
   logic       valid;
   logic       ready;
   status_type status;
   logic [7:0] frame_length;

   modport source (output valid, output status, output frame_length, input ready);
   modport sink   (input valid, input status, input frame_length, output ready);
endinterface

### hw/rtl/fcac_rsp_queue.sv
// two-word result queue that parts the checker from the result channel
// depends on fcac_pkg
module fcac_rsp_queue import fcac_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rsp_word_type     push_word,
   input  logic             pop,
   output rsp_word_type     head_word,
   output queue_status_type queue_status
);

   rsp_word_type entry_ff [2];
   rsp_word_type entry_in [2];
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic [1:0]   slot;
   logic         do_pop;

   assign do_pop = pop && (count_ff != 2'd0);

   always_comb begin
      entry_in[0] = entry_ff[0];
      entry_in[1] = entry_ff[1];
      if (do_pop) begin
         entry_in[0] = entry_ff[1];
      end
      slot = count_ff - {1'b0, do_pop};
      if (push) begin
         if (slot == 2'd0) begin
            entry_in[0] = push_word;
         end else begin
            entry_in[1] = push_word;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff[0] <= entry_in[0];
      entry_ff[1] <= entry_in[1];
   end

   assign head_word               = entry_ff[0];
   assign queue_status.head_valid = (count_ff != 2'd0);
   assign queue_status.full       = (count_ff == 2'd2);

endmodule

### hw/rtl/frame_check_additive_checksum.sv
// Checks length-prefixed frames taken one byte per word: two 0x24 start bytes, the length
// L at byte 7, a mod-256 sum of bytes 7..L+5 compared to byte L+6, and two 0x23 trailer
// bytes at L+7 and L+8. A set first_byte restarts the checker; bytes outside a frame are
// dropped. After the last byte of a frame one result word carries the status (framing
// error ahead of checksum error) and L. Each byte is handled in the cycle it is accepted,
// so a byte can be taken every cycle; the result lands in a two-word queue, and req ready
// falls only when both queue words are occupied.
// depends on fcac_pkg, fcac_if, fcac_rsp_queue and assert_macros.svh
`include "assert_macros.svh"

module frame_check_additive_checksum import fcac_pkg::*; (
   input logic       clock,
   input logic       reset,
   fcac_req_if.sink   req_chan,
   fcac_rsp_if.source rsp_chan
);

   logic [8:0] index_ff,  index_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] sum_ff,    sum_in;
   logic [7:0] expect_ff, expect_in;
   logic       good_ff,   good_in;
   logic       in_frame_ff, in_frame_in;

   logic             accept;
   logic             active;
   logic [8:0]       idx;
   logic [8:0]       len9;
   logic             push;
   rsp_word_type     push_word;
   rsp_word_type     head_word;
   queue_status_type queue_status;

   assign req_chan.ready = !queue_status.full;
   assign accept         = req_chan.valid && req_chan.ready;
   assign active         = accept && (req_chan.first_byte || in_frame_ff);

   always_comb begin
      index_in    = index_ff;
      length_in   = length_ff;
      sum_in      = sum_ff;
      expect_in   = expect_ff;
      good_in     = good_ff;
      in_frame_in = in_frame_ff;
      push        = 1'b0;
      push_word   = '{status: STATUS_OK, frame_length: length_ff};
      len9        = 9'd0;
      idx         = index_ff;

      if (active) begin
         // a first byte restarts the frame from scratch
         if (req_chan.first_byte) begin
            idx       = 9'd0;
            length_in = 8'd0;
            sum_in    = 8'd0;
            expect_in = 8'd0;
            good_in   = 1'b1;
         end
         in_frame_in = 1'b1;

         if (idx < LEN_INDEX) begin
            if (idx < 9'd2 && req_chan.data_byte != START_MARK) begin
               good_in = 1'b0;
            end
            // tentative checksum for the zero-length case
            if (idx == SUM_INDEX) begin
               expect_in = req_chan.data_byte;
            end
            index_in = idx + 9'd1;
         end else begin
            if (idx == LEN_INDEX) begin
               length_in = req_chan.data_byte;
            end
            len9 = {1'b0, length_in};
            if (idx == len9 + 9'd6) begin
               expect_in = req_chan.data_byte;
            end
            if (idx <= len9 + 9'd5) begin
               sum_in = sum_in + req_chan.data_byte;
            end
            if ((idx == len9 + 9'd7 || idx == len9 + 9'd8)
                && req_chan.data_byte != END_MARK) begin
               good_in = 1'b0;
            end
            if (idx >= len9 + 9'd8) begin
               push                   = 1'b1;
               push_word.frame_length = length_in;
               if (!good_in) begin
                  push_word.status = STATUS_FRAME_ERR;
               end else if (sum_in != expect_in) begin
                  push_word.status = STATUS_SUM_ERR;
               end else begin
                  push_word.status = STATUS_OK;
               end
               in_frame_in = 1'b0;
               index_in    = 9'd0;
            end else begin
               index_in = idx + 9'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff    <= 9'd0;
         length_ff   <= 8'd0;
         sum_ff      <= 8'd0;
         expect_ff   <= 8'd0;
         good_ff     <= 1'b1;
         in_frame_ff <= 1'b0;
      end else begin
         index_ff    <= index_in;
         length_ff   <= length_in;
         sum_ff      <= sum_in;
         expect_ff   <= expect_in;
         good_ff     <= good_in;
         in_frame_ff <= in_frame_in;
      end
   end

   fcac_rsp_queue u_rsp_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_word    (push_word),
      .pop          (rsp_chan.ready),
      .head_word    (head_word),
      .queue_status (queue_status)
   );

   assign rsp_chan.valid        = queue_status.head_valid;
   assign rsp_chan.status       = head_word.status;
   assign rsp_chan.frame_length = head_word.frame_length;

   `FCAC_ASSERT_SAME(a_full_has_head, clock, reset, !req_chan.ready, rsp_chan.valid)
   `FCAC_ASSERT_SAME(a_index_bound, clock, reset, 1'b1, index_ff <= INDEX_MAX)
   `FCAC_ASSERT_SAME(a_idle_index_zero, clock, reset, !in_frame_ff, index_ff == 9'd0)
   `FCAC_ASSERT_NEXT(a_end_closes, clock, reset, push, !in_frame_ff && rsp_chan.valid)

endmodule

### bench/frame_check_additive_checksum_checker.sv
`timescale 1ns / 1ps
// watches the byte and verdict channels of frame_check_additive_checksum, tracks each frame
// and compares every verdict word with the one predicted; depends on fcac_pkg and fcac_if
module frame_check_additive_checksum_checker import fcac_pkg::*; (
   input  logic clock,
   input  logic reset,
   fcac_req_if  req_chan,
   fcac_rsp_if  rsp_chan,
   output int   fail_count,
   output int   pending,
   output int   ok_count,
   output int   framing_count,
   output int   sum_count
);

   logic [8:0]   byte_pos;
   logic [7:0]   frame_len;
   logic [7:0]   sum_acc;
   logic [7:0]   sum_field;
   logic         marks_good;
   logic         frame_open;
   rsp_word_type verdicts[$];

   task automatic track_byte(input logic first, input logic [7:0] b);
      int unsigned  pos;
      int unsigned  len;
      rsp_word_type verdict;
      if (first) begin
         byte_pos   = '0;
         frame_len  = '0;
         sum_acc    = '0;
         sum_field  = '0;
         marks_good = 1'b1;
         frame_open = 1'b1;
      end else if (!frame_open) begin
         return;
      end
      pos = byte_pos;
      // header: start marks, and byte 6 held in case the length turns out zero
      if (pos < LEN_INDEX) begin
         if (pos < 2 && b != START_MARK) marks_good = 1'b0;
         if (pos == SUM_INDEX) sum_field = b;
         byte_pos = byte_pos + 9'd1;
         return;
      end
      if (pos == LEN_INDEX) frame_len = b;
      len = frame_len;
      if (pos == len + 6) sum_field = b;
      if (pos <= len + 5) sum_acc = sum_acc + b;
      if ((pos == len + 7 || pos == len + 8) && b != END_MARK) marks_good = 1'b0;
      if (pos >= len + 8) begin
         if (!marks_good) verdict.status = STATUS_FRAME_ERR;
         else if (sum_acc != sum_field) verdict.status = STATUS_SUM_ERR;
         else verdict.status = STATUS_OK;
         verdict.frame_length = frame_len;
         verdicts.push_back(verdict);
         frame_open = 1'b0;
         byte_pos   = '0;
         return;
      end
      byte_pos = byte_pos + 9'd1;
   endtask

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         byte_pos      = '0;
         frame_len     = '0;
         sum_acc       = '0;
         sum_field     = '0;
         marks_good    = 1'b1;
         frame_open    = 1'b0;
         verdicts.delete();
         fail_count    = 0;
         ok_count      = 0;
         framing_count = 0;
         sum_count     = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            track_byte(req_chan.first_byte, req_chan.data_byte);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (verdicts.size() == 0) begin
               $display("%0t: verdict with none expected, got status %0d length %0d",
                        $time, rsp_chan.status, rsp_chan.frame_length);
               fail_count++;
            end else begin
               want = verdicts.pop_front();
               if (rsp_chan.status !== want.status ||
                   rsp_chan.frame_length !== want.frame_length) begin
                  $display("%0t: mismatch, expected status %0d len %0d, got status %0d len %0d",
                           $time, want.status, want.frame_length,
                           rsp_chan.status, rsp_chan.frame_length);
                  fail_count++;
               end
               case (want.status)
                  STATUS_OK:        ok_count++;
                  STATUS_FRAME_ERR: framing_count++;
                  default:          sum_count++;
               endcase
            end
         end
      end
      pending = verdicts.size();
   end

endmodule

### bench/frame_check_additive_checksum_test.sv
`timescale 1ns / 1ps
// stimulus and verdict for frame_check_additive_checksum: directed frames, then random
// good and damaged frames with gaps on both channels; depends on fcac_pkg, fcac_if, the block
// and frame_check_additive_checksum_checker
module frame_check_additive_checksum_test;
   import fcac_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int BYTE_TARGET  = 650;
   localparam int FRAME_TARGET = 16;
   localparam int DRAIN_CYCLES = 20;

   typedef enum int {
      FLAW_NONE,
      FLAW_START,
      FLAW_SUM,
      FLAW_TRAILER,
      FLAW_CUT
   } flaw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;
   int   cycles      = 0;
   int   bytes_sent  = 0;
   int   frames_sent = 0;
   int   longest     = 0;
   int   fail_count;
   int   pending;
   int   ok_count;
   int   framing_count;
   int   sum_count;

   fcac_req_if req_chan ();
   fcac_rsp_if rsp_chan ();

   frame_check_additive_checksum DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   frame_check_additive_checksum_checker verdict_watch (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending       (pending),
      .ok_count      (ok_count),
      .framing_count (framing_count),
      .sum_count     (sum_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d verdicts outstanding", cycles, pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // result side stalls about 30 percent of cycles outside the calm stretch
   always @(negedge clock) begin
      rsp_chan.ready <= !reset && (calm || $urandom_range(0, 99) >= 30);
   end

   task automatic send_byte(input logic first, input logic [7:0] data);
      while (!calm && $urandom_range(0, 99) < 30) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.first_byte <= first;
      req_chan.data_byte  <= data;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_frame(input int len, input flaw_type flaw);
      logic [7:0] body[$];
      logic [7:0] sum;
      int         cut;
      sum = 8'h00;
      for (int i = 0; i <= len + 8; i++) begin
         if (i < 2) body.push_back(START_MARK);
         else if (i == LEN_INDEX) body.push_back(8'(len));
         else if (i == len + 6) body.push_back(sum);
         else if (i >= len + 7) body.push_back(END_MARK);
         else body.push_back(8'($urandom));
         if (i >= LEN_INDEX && i <= len + 5) sum = sum + body[i];
      end
      case (flaw)
         FLAW_START: body[$urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
         FLAW_SUM: begin
            if (len >= 2) body[len + 6] ^= 8'($urandom_range(1, 255));
         end
         FLAW_TRAILER: begin
            // for length zero byte 7 is the length, so leave it alone
            if (len >= 1) body[len + 7 + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
         end
         default: ;
      endcase
      cut = (flaw == FLAW_CUT) ? $urandom_range(1, len + 8) : len + 9;
      calm <= (bytes_sent >= 250 && bytes_sent < 400);
      for (int pos = 0; pos < cut; pos++) send_byte(pos == 0, body[pos]);
      bytes_sent += cut;
      if (flaw != FLAW_CUT) begin
         frames_sent++;
         if (len > longest) longest = len;
      end
   endtask

   initial begin
      int       len;
      int       pick;
      flaw_type flaw;
      req_chan.valid      = 1'b0;
      req_chan.first_byte = 1'b0;
      req_chan.data_byte  = 8'h00;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // stray words while idle, then an open frame dropped by a restart
      send_byte(1'b0, 8'h00);
      send_byte(1'b0, 8'hFF);
      send_byte(1'b1, START_MARK);
      send_byte(1'b0, START_MARK);
      send_byte(1'b0, 8'hFF);
      // length zero ends on a bad trailer, length one on an empty sum
      send_frame(0, FLAW_NONE);
      send_frame(1, FLAW_NONE);

      while (bytes_sent < BYTE_TARGET || frames_sent < FRAME_TARGET) begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom));
         end
         pick = $urandom_range(0, 49);
         if (frames_sent == 6 || pick == 0) len = 255;
         else if (pick == 1) len = $urandom_range(100, 254);
         else len = $urandom_range(0, 14);
         case ($urandom_range(0, 9))
            6:       flaw = FLAW_START;
            7:       flaw = FLAW_SUM;
            8:       flaw = FLAW_TRAILER;
            9:       flaw = FLAW_CUT;
            default: flaw = FLAW_NONE;
         endcase
         send_frame(len, flaw);
      end
      req_chan.valid <= 1'b0;
      calm <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("sent %0d frame bytes, %0d complete frames, lengths up to %0d",
               bytes_sent, frames_sent, longest);
      $display("verdicts: %0d ok, %0d framing error, %0d checksum error",
               ok_count, framing_count, sum_count);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
